@@ hw/rtl/fdmg_pkg.sv @@
// ----------------------------------------------------------------------------
// fdmg_pkg
// Shared sizes, register codes and request types of the motion gate.
// ----------------------------------------------------------------------------
package fdmg_pkg;

	// Frame store geometry
	localparam int unsigned MAX_FRAME_PIXELS = 65536;
	localparam int unsigned ADDR_W  = $clog2(MAX_FRAME_PIXELS);
	localparam int unsigned FILL_W  = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int unsigned CNT_W   = FILL_W;

	// Field widths
	localparam int unsigned PIX_W     = 8;
	localparam int unsigned CHG_W     = 17;
	localparam int unsigned QUIET_W   = 16;
	localparam int unsigned CFG_W     = 17;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CMP_W     = (CNT_W > CHG_W) ? CNT_W : CHG_W;

	// Register reset values
	localparam logic [PIX_W-1:0]   THRESHOLD_RST   = PIX_W'(45);
	localparam logic [CHG_W-1:0]   COUNT_LIMIT_RST = '0;
	localparam logic [QUIET_W-1:0] QUIET_LIMIT_RST = '0;
	localparam logic [QUIET_W-1:0] QUIET_MAX       = '1;

	// Result queue
	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
	localparam int unsigned RES_OCC_W = $clog2(RES_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_DIFF_THRESHOLD = 2'd0,
		REG_CHANGE_COUNT_LIMIT   = 2'd1,
		REG_QUIET_FRAME_LIMIT    = 2'd2
	} cfg_reg_t;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [PIX_W-1:0]  pix_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
	} fs_rd_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		pix_t  data;
	} fs_wr_t;

	typedef struct packed {
		logic [CHG_W-1:0] changed_pixels;
		logic             moving;
		logic             movement_started;
		logic             movement_stopped;
		logic             frame_forwarded;
	} res_t;

endpackage

@@ hw/rtl/fdmg_if.sv @@
// ----------------------------------------------------------------------------
// fdmg_if
// Valid/ready channels for pixel requests and frame results.
// ----------------------------------------------------------------------------
interface fdmg_pix_if;
	import fdmg_pkg::*;

	logic       valid;
	logic       ready;
	pix_t       pixel;
	logic       frame_end;

	modport source (output valid, output pixel, output frame_end, input ready);
	modport sink   (input valid, input pixel, input frame_end, output ready);
endinterface

interface fdmg_res_if;
	import fdmg_pkg::*;

	logic             valid;
	logic             ready;
	logic [CHG_W-1:0] changed_pixels;
	logic             moving;
	logic             movement_started;
	logic             movement_stopped;
	logic             frame_forwarded;

	modport source (
		output valid, output changed_pixels, output moving,
		output movement_started, output movement_stopped, output frame_forwarded,
		input ready
	);
	modport sink (
		input valid, input changed_pixels, input moving,
		input movement_started, input movement_stopped, input frame_forwarded,
		output ready
	);
endinterface

@@ hw/rtl/frame_difference_motion_gate.sv @@
// ----------------------------------------------------------------------------
// frame_difference_motion_gate
// Frame differencing against a stored previous frame, with a movement gate.
// ----------------------------------------------------------------------------
// Pixels enter on pix_in in raster order, frame_end high on the last pixel
// of each frame. One result leaves on res_out per frame, carrying the
// changed-pixel count, the gate state and the start, stop and forward flags.
// Registers are to be written through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
//
// Throughput is one pixel per cycle while pix_in.ready is high: the frame
// store does one read and one write each cycle, and a pixel that reads the
// entry written by the pixel before it (one-pixel frames) takes the forwarded value.
// The last pixel of a frame passes store read, compare and write-back, then
// count and gate update into a 4-entry result queue.
//
// Reset clears the gate, the counters and the fill mark of the store, so
// unwritten entries read as zero with no clearing pass; pixels are taken
// from the first cycle after reset.
// When the receiver stalls, results collect in the queue; pix_in.ready drops
// once queued plus in-flight frame ends reach the queue depth.
// ----------------------------------------------------------------------------
module frame_difference_motion_gate (
	input  logic                          clk,
	input  logic                          arst_n,
	fdmg_pix_if.sink                      pix_in,
	fdmg_res_if.source                    res_out,
	input  logic                          cfg_we,
	input  logic [fdmg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fdmg_pkg::CFG_W-1:0]     cfg_data
);
	import fdmg_pkg::*;

	// Configuration
	pix_t               thresh_q;
	logic [CHG_W-1:0]   count_limit_q;
	logic [QUIET_W-1:0] quiet_limit_q;

	// Input side
	logic               accept;
	addr_t              pix_addr_q;
	fs_rd_t             rd_req;
	fs_wr_t             wr_req;
	pix_t               old_pix;

	// Stage 1: compare and write back
	logic               valid_s1;
	pix_t               pix_s1;
	logic               end_s1;
	addr_t              addr_s1;
	pix_t               diff;
	logic               changed;

	// Stage 2: count and gate
	logic               valid_s2;
	logic               changed_s2;
	logic               end_s2;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_next;
	logic               gate_q;
	logic [QUIET_W-1:0] quiet_q;
	logic               movement;
	logic               gate_next;
	logic [QUIET_W-1:0] quiet_next;
	res_t               res_new;

	// Result queue
	res_t               res_mem [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_OCC_W-1:0] occ_q;
	logic [RES_OCC_W:0]   committed;
	logic               push;
	logic               pop;
	res_t               res_head;

	// Register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q      <= THRESHOLD_RST;
			count_limit_q <= COUNT_LIMIT_RST;
			quiet_limit_q <= QUIET_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PIXEL_DIFF_THRESHOLD: thresh_q      <= cfg_data[PIX_W-1:0];
				REG_CHANGE_COUNT_LIMIT:   count_limit_q <= cfg_data[CHG_W-1:0];
				REG_QUIET_FRAME_LIMIT:    quiet_limit_q <= cfg_data[QUIET_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold requests while queued and pending results could overflow the queue
	assign committed = (RES_OCC_W+1)'(occ_q) + (RES_OCC_W+1)'(valid_s1 && end_s1)
		+ (RES_OCC_W+1)'(valid_s2 && end_s2);
	assign pix_in.ready = committed < (RES_OCC_W+1)'(RES_DEPTH);
	assign accept = pix_in.valid && pix_in.ready;

	// Advance the raster address; wrap at the store size, restart after frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_addr_q <= '0;
		end else if (accept) begin
			if (pix_in.frame_end || (pix_addr_q == ADDR_W'(MAX_FRAME_PIXELS - 1))) begin
				pix_addr_q <= '0;
			end else begin
				pix_addr_q <= pix_addr_q + ADDR_W'(1);
			end
		end
	end

	assign rd_req.en   = accept;
	assign rd_req.addr = pix_addr_q;

	fdmg_frame_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rd_req),
		.wr     (wr_req),
		.rdata  (old_pix)
	);

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pix_in.pixel;
			end_s1  <= pix_in.frame_end;
			addr_s1 <= pix_addr_q;
		end
	end

	// Compare against the stored pixel and write the new one back
	assign diff    = (pix_s1 > old_pix) ? (pix_s1 - old_pix) : (old_pix - pix_s1);
	assign changed = diff > thresh_q;

	assign wr_req.en   = valid_s1;
	assign wr_req.addr = addr_s1;
	assign wr_req.data = pix_s1;

	// Stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			changed_s2 <= changed;
			end_s2     <= end_s1;
		end
	end

	// Saturating count including this pixel
	always_comb begin
		count_next = count_q;
		if (changed_s2 && (count_q < CNT_W'(MAX_FRAME_PIXELS))) begin
			count_next = count_q + CNT_W'(1);
		end
	end

	// Gate update at frame end
	assign movement = CMP_W'(count_next) >= CMP_W'(count_limit_q);

	always_comb begin
		gate_next                = gate_q;
		quiet_next               = quiet_q;
		res_new.movement_started = 1'b0;
		res_new.movement_stopped = 1'b0;
		res_new.frame_forwarded  = gate_q;
		if (!gate_q) begin
			if (movement) begin
				gate_next                = 1'b1;
				quiet_next               = '0;
				res_new.movement_started = 1'b1;
				res_new.frame_forwarded  = 1'b1;
			end
		end else if (movement) begin
			quiet_next = '0;
		end else begin
			if (quiet_q != QUIET_MAX) begin
				quiet_next = quiet_q + QUIET_W'(1);
			end
			if (quiet_next >= quiet_limit_q) begin
				gate_next                = 1'b0;
				res_new.movement_stopped = 1'b1;
			end
		end
		res_new.changed_pixels = CHG_W'(count_next);
		res_new.moving         = gate_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			gate_q  <= 1'b0;
			quiet_q <= '0;
		end else if (valid_s2) begin
			if (end_s2) begin
				count_q <= '0;
				gate_q  <= gate_next;
				quiet_q <= quiet_next;
			end else begin
				count_q <= count_next;
			end
		end
	end

	// Result queue
	assign push = valid_s2 && end_s2;
	assign pop  = res_out.valid && res_out.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			res_mem[wr_ptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + RES_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			occ_q <= occ_q + RES_OCC_W'(push) - RES_OCC_W'(pop);
		end
	end

	assign res_head                 = res_mem[rd_ptr_q];
	assign res_out.valid            = occ_q != '0;
	assign res_out.changed_pixels   = res_head.changed_pixels;
	assign res_out.moving           = res_head.moving;
	assign res_out.movement_started = res_head.movement_started;
	assign res_out.movement_stopped = res_head.movement_stopped;
	assign res_out.frame_forwarded  = res_head.frame_forwarded;

	// Queued and in-flight results never exceed the queue depth
	assert property (@(posedge clk) disable iff (!arst_n)
		committed <= (RES_OCC_W+1)'(RES_DEPTH))
		else $error("result queue overcommitted");

	// No push into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (occ_q < RES_OCC_W'(RES_DEPTH)) || pop)
		else $error("result queue overflow");

	// Opening frame leaves the gate open and is forwarded
	assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.movement_started |->
			res_out.moving && res_out.frame_forwarded && !res_out.movement_stopped)
		else $error("inconsistent start result");

	// Closing frame leaves the gate closed and is still forwarded
	assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.movement_stopped |->
			!res_out.moving && res_out.frame_forwarded)
		else $error("inconsistent stop result");

	// Count restarts after every frame end
	assert property (@(posedge clk) disable iff (!arst_n)
		push |=> count_q == '0)
		else $error("change count not cleared at frame end");

endmodule

@@ hw/rtl/fdmg_frame_store.sv @@
// ----------------------------------------------------------------------------
// fdmg_frame_store
// Previous-frame memory, one read and one write port, registered read.
// Entries at or above the fill mark read as zero; a read of the entry being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module fdmg_frame_store (
	input  logic            clk,
	input  logic            arst_n,
	input  fdmg_pkg::fs_rd_t rd,
	input  fdmg_pkg::fs_wr_t wr,
	output fdmg_pkg::pix_t   rdata
);
	import fdmg_pkg::*;

	pix_t              mem [MAX_FRAME_PIXELS];
	pix_t              mem_rdata_q;
	pix_t              wr_hold_q;
	logic              hit_q;
	logic              valid_q;
	logic [FILL_W-1:0] fill_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read port, with collision and fill checks taken alongside
	always_ff @(posedge clk) begin
		if (rd.en) begin
			mem_rdata_q <= mem[rd.addr];
			wr_hold_q   <= wr.data;
			hit_q       <= wr.en && (wr.addr == rd.addr);
			valid_q     <= FILL_W'(rd.addr) < fill_q;
		end
	end

	// Advance the fill mark; entries are always written from zero upwards
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (wr.en && (FILL_W'(wr.addr) == fill_q)) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	// Select forwarded, stored or blank data
	always_comb begin
		if (hit_q) begin
			rdata = wr_hold_q;
		end else if (valid_q) begin
			rdata = mem_rdata_q;
		end else begin
			rdata = '0;
		end
	end

	// Writes never skip past the fill mark
	assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> FILL_W'(wr.addr) <= fill_q)
		else $error("frame store written beyond fill mark");

endmodule
